>>> rtl/core/kcl_pkg.sv
`default_nettype none
package kcl_pkg;

  localparam int unsigned ROW_W = 4;
  localparam int unsigned COL_W = 2;
  localparam int unsigned KEY_W = 5;
  localparam int unsigned SEG_W = 8;
  localparam int unsigned DEB_W = 8;
  localparam int unsigned PER_W = 4;
  localparam int unsigned SINCE_CHG_W = 9;

  localparam logic [KEY_W-1:0] KEY_NONE = 5'd31;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

  // configuration register indexes
  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_SCAN_PERIOD = 1'b1;

  // decoded key seen on the scanned column
  typedef struct packed {
    logic       pressed;
    logic       enterable;  // digit or A-D; star and hash are not
    logic [3:0] pos;        // row*4 + column
    logic [3:0] code;       // 0-9, A-D = 10-13
  } kcl_key_t;

  // key entry request towards the code store
  typedef struct packed {
    logic       step;
    logic       enter;
    logic [3:0] code;
    logic [1:0] col;
  } kcl_entry_t;

  // state of the code store after the tick
  typedef struct packed {
    logic             locked;
    logic             enrolling;
    logic [SEG_W-1:0] segments;
  } kcl_status_t;

  // keypad position to {enterable, code}
  function automatic logic [4:0] key_entry(input logic [3:0] pos);
    logic [4:0] r;
    unique case (pos)
      4'd0:  r = {1'b1, 4'd1};
      4'd1:  r = {1'b1, 4'd2};
      4'd2:  r = {1'b1, 4'd3};
      4'd3:  r = {1'b1, 4'd10};
      4'd4:  r = {1'b1, 4'd4};
      4'd5:  r = {1'b1, 4'd5};
      4'd6:  r = {1'b1, 4'd6};
      4'd7:  r = {1'b1, 4'd11};
      4'd8:  r = {1'b1, 4'd7};
      4'd9:  r = {1'b1, 4'd8};
      4'd10: r = {1'b1, 4'd9};
      4'd11: r = {1'b1, 4'd12};
      4'd13: r = {1'b1, 4'd0};
      4'd15: r = {1'b1, 4'd13};
      default: r = {1'b0, 4'd0};  // star, hash
    endcase
    return r;
  endfunction

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] code);
    logic [SEG_W-1:0] s;
    unique case (code)
      4'd0:  s = 8'h40;
      4'd1:  s = 8'h79;
      4'd2:  s = 8'h24;
      4'd3:  s = 8'h30;
      4'd4:  s = 8'h19;
      4'd5:  s = 8'h12;
      4'd6:  s = 8'h02;
      4'd7:  s = 8'h78;
      4'd8:  s = 8'h80;
      4'd9:  s = 8'h18;
      4'd10: s = 8'h08;
      4'd11: s = 8'h03;
      4'd12: s = 8'h46;
      4'd13: s = 8'h21;
      4'd14: s = 8'h06;
      default: s = 8'h0E;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/kcl_key_decode.sv
`default_nettype none
module kcl_key_decode (
  input  wire logic [kcl_pkg::ROW_W-1:0] row_lines,
  input  wire logic [kcl_pkg::COL_W-1:0] col,
  output kcl_pkg::kcl_key_t              key
);

  logic [4:0] ent;

  always_comb begin
    key = '0;
    // highest pressed row wins
    for (int j = 0; j < kcl_pkg::ROW_W; j++) begin
      if (!row_lines[j]) begin
        key.pressed = 1'b1;
        key.pos = {2'(j), col};
      end
    end
    ent = kcl_pkg::key_entry(key.pos);
    key.enterable = ent[4];
    key.code = ent[3:0];
  end

endmodule
`default_nettype wire

>>> rtl/core/kcl_code_store.sv
`default_nettype none
module kcl_code_store #(
  parameter int unsigned CODE_LENGTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire kcl_pkg::kcl_entry_t entry,
  output kcl_pkg::kcl_status_t     status
);

  localparam int unsigned CNT_W = $clog2(CODE_LENGTH + 1);
  localparam int unsigned IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int unsigned DW = (CNT_W > 2) ? CNT_W : 2;
  localparam logic [CNT_W-1:0] LEN = CNT_W'(CODE_LENGTH);

  logic [3:0]       attempt_r [CODE_LENGTH];
  logic [3:0]       attempt_nxt [CODE_LENGTH];
  logic [3:0]       stored_r [CODE_LENGTH];
  logic [3:0]       stored_nxt [CODE_LENGTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             lock_r, lock_nxt;
  logic             enrol_r, enrol_nxt;

  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] cnt_inc;
  logic             same;
  logic [DW-1:0]    cnt_ext, col_ext, pos;
  logic             show;

  always_comb begin
    attempt_nxt = attempt_r;
    stored_nxt = stored_r;
    cnt_nxt = cnt_r;
    lock_nxt = lock_r;
    enrol_nxt = enrol_r;

    // a full group restarts at entry 0 on the next key
    base = (cnt_r >= LEN) ? '0 : cnt_r;
    cnt_inc = base + CNT_W'(1);
    if (entry.enter) begin
      attempt_nxt[base[IDX_W-1:0]] = entry.code;
    end

    same = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (stored_r[i] != attempt_nxt[i]) begin
        same = 1'b0;
      end
    end

    if (entry.enter) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc == LEN) begin
        if (enrol_r) begin
          stored_nxt = attempt_nxt;
          cnt_nxt = '0;
          lock_nxt = 1'b1;
          enrol_nxt = 1'b0;
        end else begin
          lock_nxt = !same;
        end
      end
    end

    // digit d shows the d-th most recent key of an unfinished group
    cnt_ext = DW'(cnt_nxt);
    col_ext = DW'(entry.col);
    show = (col_ext < cnt_ext) && (cnt_nxt < LEN);
    pos = cnt_ext - DW'(1) - col_ext;

    status.locked = lock_nxt;
    status.enrolling = enrol_nxt;
    status.segments = show ? kcl_pkg::seg_pattern(attempt_nxt[pos[IDX_W-1:0]])
                           : kcl_pkg::SEG_BLANK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      lock_r <= 1'b0;
      enrol_r <= 1'b1;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        attempt_r[i] <= '0;
        stored_r[i] <= '0;
      end
    end else if (entry.step) begin
      cnt_r <= cnt_nxt;
      lock_r <= lock_nxt;
      enrol_r <= enrol_nxt;
      attempt_r <= attempt_nxt;
      stored_r <= stored_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/keypad_code_lock.sv
// Keypad code lock, one tick per request.
// A request is registered in the input stage, and its result in the result stage.
// Throughput: one request per cycle; the input and result registers each
// stall only while the next stage holds.
// Reset (synchronous, rst_n low): pipeline empty, debounce 20, scan period 2,
// column 0, enrollment mode, unlocked, all key and code storage cleared.
`default_nettype none
module keypad_code_lock #(
  parameter int unsigned CODE_LENGTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [3:0] row_lines
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata   // [1:0] scan_column, [2] display_update,
                                       // [4:3] display_digit, [12:5] segments,
                                       // [13] locked, [14] enrolling
);

  localparam int unsigned SCW = kcl_pkg::SINCE_CHG_W;
  localparam logic [SCW-1:0] SC_MAX = '1;
  localparam logic [kcl_pkg::PER_W-1:0] SS_MAX = '1;

  // configuration
  logic [kcl_pkg::DEB_W-1:0] debounce_r;
  logic [kcl_pkg::PER_W-1:0] period_r;

  // input stage
  logic                      in_valid_r;
  logic [kcl_pkg::ROW_W-1:0] in_rows_r;

  // scan state
  logic [kcl_pkg::COL_W-1:0] col_r, col_nxt;
  logic [kcl_pkg::KEY_W-1:0] last_key_r [4];
  logic [SCW-1:0]            since_change_r, since_change_nxt;
  logic [kcl_pkg::PER_W-1:0] since_scan_r, since_scan_nxt;

  // result stage
  logic        out_valid_r;
  logic [15:0] out_data_r, out_data_nxt;

  logic                      move;
  kcl_pkg::kcl_key_t         key;
  kcl_pkg::kcl_entry_t       entry;
  kcl_pkg::kcl_status_t      status;
  logic [kcl_pkg::KEY_W-1:0] key_val;
  logic [SCW-1:0]            sc_inc;
  logic                      change;
  logic                      upd;
  logic [kcl_pkg::SEG_W-1:0] seg;

  assign move = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || move;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  kcl_key_decode u_decode (
    .row_lines (in_rows_r),
    .col       (col_r),
    .key       (key)
  );

  kcl_code_store #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .entry  (entry),
    .status (status)
  );

  always_comb begin
    key_val = key.pressed ? ({1'b0, key.pos} + 5'd1) : kcl_pkg::KEY_NONE;
    sc_inc = (since_change_r == SC_MAX) ? since_change_r : since_change_r + SCW'(1);
    change = (last_key_r[col_r] != key_val) && (sc_inc > SCW'(debounce_r));
    since_change_nxt = change ? '0 : sc_inc;

    entry.step = move;
    entry.enter = move && change && key.pressed && key.enterable;
    entry.code = key.code;
    entry.col = col_r;

    since_scan_nxt = (since_scan_r == SS_MAX) ? since_scan_r
                                              : since_scan_r + kcl_pkg::PER_W'(1);
    upd = (since_scan_nxt >= period_r);
    col_nxt = col_r;
    if (upd) begin
      since_scan_nxt = '0;
      col_nxt = col_r + kcl_pkg::COL_W'(1);
    end
    seg = upd ? status.segments : kcl_pkg::SEG_BLANK;

    out_data_nxt = {1'b0, status.enrolling, status.locked, seg,
                    upd ? col_r : kcl_pkg::COL_W'(0), upd, col_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= 8'd20;
      period_r <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kcl_pkg::CFG_DEBOUNCE:    debounce_r <= cfg_wdata;
        kcl_pkg::CFG_SCAN_PERIOD: period_r <= cfg_wdata[kcl_pkg::PER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_rows_r <= in_tdata[kcl_pkg::ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      since_change_r <= '0;
      since_scan_r <= '0;
      for (int i = 0; i < 4; i++) begin
        last_key_r[i] <= '0;
      end
    end else if (move) begin
      col_r <= col_nxt;
      since_change_r <= since_change_nxt;
      since_scan_r <= since_scan_nxt;
      if (change) begin
        last_key_r[col_r] <= key_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= out_data_nxt;
    end
  end

  // no refresh means digit 0 and a blank pattern
  a_blank_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r[2]) |-> (out_data_r[4:3] == 2'd0 && out_data_r[12:5] == 8'hFF))
    else $error("display data without refresh");

  // the block cannot be locked while still enrolling
  a_enrol_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[14]) |-> !out_data_r[13])
    else $error("locked during enrollment");

  // the column holds when no advance was due
  a_col_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (move && !upd) |=> $stable(col_r))
    else $error("column moved without advance");

endmodule
`default_nettype wire

>>> tb/sv/kcl_checker.sv
module kcl_checker #(
  parameter int unsigned CODE_LEN = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] row_lines
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [1:0] scan_column, [2] display_update,
                                  // [4:3] display_digit, [12:5] segments,
                                  // [13] locked, [14] enrolling
  output int          fail_count,
  output int          pending
);

  // active-low glyphs for key codes 0..15, code 0 in the low byte
  localparam logic [16*8-1:0] GLYPHS = {
    8'h0E, 8'h06, 8'h21, 8'h46, 8'h03, 8'h08, 8'h18, 8'h80,
    8'h78, 8'h02, 8'h12, 8'h19, 8'h30, 8'h24, 8'h79, 8'h40
  };

  typedef struct packed {
    logic [1:0] col;
    logic       upd;
    logic [1:0] digit;
    logic [7:0] seg;
    logic       locked;
    logic       enrolling;
  } tick_t;

  tick_t ticks_due [$];

  // lock state as seen from the pins
  logic [1:0]  scan_col;
  logic [4:0]  seen_key [4];
  logic [8:0]  ticks_since_key;
  logic [3:0]  ticks_since_scan;
  int unsigned n_entered;
  logic [3:0]  attempt [CODE_LEN];
  logic [3:0]  secret [CODE_LEN];
  logic        lock_q;
  logic        enrol_q;
  logic [7:0]  debounce_q;
  logic [3:0]  period_q;

  // {enterable, code} for the key at row r, column c
  function automatic logic [4:0] pad_code(input logic [1:0] r, input logic [1:0] c);
    logic [3:0] v;
    if (c == 2'd3) begin
      v = 4'd10 + r;
      return {1'b1, v};
    end
    if (r != 2'd3) begin
      v = 4'(r * 3 + c + 1);
      return {1'b1, v};
    end
    if (c == 2'd1) return {1'b1, 4'd0};
    return 5'd0;  // star or hash
  endfunction

  function automatic void take_digit(input logic [3:0] code);
    logic same;
    if (n_entered >= CODE_LEN) n_entered = 0;
    attempt[n_entered] = code;
    n_entered++;
    if (n_entered == CODE_LEN) begin
      if (enrol_q) begin
        for (int i = 0; i < CODE_LEN; i++) secret[i] = attempt[i];
        n_entered = 0;
        lock_q = 1'b1;
        enrol_q = 1'b0;
      end else begin
        same = 1'b1;
        for (int i = 0; i < CODE_LEN; i++)
          if (secret[i] != attempt[i]) same = 1'b0;
        lock_q = !same;
      end
    end
  endfunction

  function automatic tick_t run_tick(input logic [3:0] rows);
    tick_t t;
    logic [1:0] c;
    logic [1:0] row_hit;
    logic [4:0] key;
    logic [4:0] entry;
    c = scan_col;
    key = kcl_pkg::KEY_NONE;
    row_hit = 2'd0;
    // highest pressed row wins
    for (int j = 0; j < 4; j++)
      if (!rows[j]) begin
        key = 5'(j * 4 + c + 1);
        row_hit = 2'(j);
      end
    if (ticks_since_key != 9'd511) ticks_since_key++;
    if (seen_key[c] != key && ticks_since_key > debounce_q) begin
      ticks_since_key = 9'd0;
      if (key != kcl_pkg::KEY_NONE) begin
        entry = pad_code(row_hit, c);
        if (entry[4]) take_digit(entry[3:0]);
      end
      seen_key[c] = key;
    end
    if (ticks_since_scan != 4'd15) ticks_since_scan++;
    t.upd = 1'b0;
    t.digit = 2'd0;
    t.seg = kcl_pkg::SEG_BLANK;
    if (ticks_since_scan >= period_q) begin
      t.upd = 1'b1;
      t.digit = c;
      if (c < n_entered && n_entered < CODE_LEN)
        t.seg = GLYPHS[attempt[n_entered - 1 - c] * 8 +: 8];
      scan_col = c + 2'd1;
      ticks_since_scan = 4'd0;
    end
    t.col = c;
    t.locked = lock_q;
    t.enrolling = enrol_q;
    return t;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    tick_t want;
    if (!rst_n) begin
      scan_col = 2'd0;
      for (int i = 0; i < 4; i++) seen_key[i] = 5'd0;
      ticks_since_key = 9'd0;
      ticks_since_scan = 4'd0;
      n_entered = 0;
      for (int i = 0; i < CODE_LEN; i++) begin
        attempt[i] = 4'd0;
        secret[i] = 4'd0;
      end
      lock_q = 1'b0;
      enrol_q = 1'b1;
      debounce_q = 8'd20;
      period_q = 4'd2;
      ticks_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == kcl_pkg::CFG_DEBOUNCE) debounce_q = cfg_wdata;
        else period_q = cfg_wdata[3:0];
      end
      if (in_tvalid && in_tready) ticks_due.push_back(run_tick(in_tdata[3:0]));
      if (out_tvalid && out_tready) begin
        if (ticks_due.size() == 0) begin
          note_mismatch("unexpected result", 0, out_tdata);
        end else begin
          want = ticks_due.pop_front();
          if (out_tdata[1:0] != want.col)
            note_mismatch("scan_column", want.col, out_tdata[1:0]);
          if (out_tdata[2] != want.upd)
            note_mismatch("display_update", want.upd, out_tdata[2]);
          if (out_tdata[4:3] != want.digit)
            note_mismatch("display_digit", want.digit, out_tdata[4:3]);
          if (out_tdata[12:5] != want.seg)
            note_mismatch("segments", want.seg, out_tdata[12:5]);
          if (out_tdata[13] != want.locked)
            note_mismatch("locked", want.locked, out_tdata[13]);
          if (out_tdata[14] != want.enrolling)
            note_mismatch("enrolling", want.enrolling, out_tdata[14]);
        end
      end
    end
    pending = ticks_due.size();
  end

endmodule

>>> tb/sv/tb_keypad_code_lock.sv
module tb_keypad_code_lock;

  localparam int POS_STAR = 12;
  localparam int POS_ZERO = 13;
  localparam int POS_HASH = 14;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [3:0] row_lines
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [1:0] scan_column, [2] display_update,
                           // [4:3] display_digit, [12:5] segments,
                           // [13] locked, [14] enrolling

  int fail_count;
  int pending;

  bit in_idle;
  bit out_idle;
  int stall_left;
  int n_sent;

  // keypad side: which column the lock is scanning for the next request
  logic [7:0] deb_now;
  logic [3:0] per_now;
  logic [1:0] pad_col;
  int         pad_scan;
  int         grp_pos;
  bit         grp_secret;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  keypad_code_lock #(
    .CODE_LENGTH(4)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  kcl_checker #(
    .CODE_LEN(4)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // result side backpressure in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (out_idle && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_rows(input logic [3:0] rows);
    @(negedge clk);
    if (in_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, rows};
    do @(posedge clk); while (!in_tready);
    n_sent++;
    if (pad_scan < 15) pad_scan++;
    if (pad_scan >= per_now) begin
      pad_col = pad_col + 2'd1;
      pad_scan = 0;
    end
  endtask

  // only between phases, with nothing in flight
  task automatic set_config(input logic [7:0] deb, input logic [3:0] per);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= kcl_pkg::CFG_DEBOUNCE;
    cfg_wdata <= deb;
    @(negedge clk);
    cfg_index <= kcl_pkg::CFG_SCAN_PERIOD;
    cfg_wdata <= {4'b0000, per};
    @(negedge clk);
    cfg_we <= 1'b0;
    deb_now = deb;
    per_now = per;
    in_idle = $urandom_range(0, 3) != 0;
    out_idle = $urandom_range(0, 3) != 0;
  endtask

  // press long enough to get past debounce and one full column sweep, then release
  task automatic hit_key(input int pos);
    int hold;
    hold = deb_now + 1 + 4 * (per_now == 0 ? 1 : per_now) + $urandom_range(0, 3);
    repeat (hold) push_rows(pad_col == pos % 4 ? ~(4'b0001 << (pos / 4)) : 4'hF);
    repeat (hold) push_rows(4'hF);
  endtask

  task automatic run_keypad(input int n_items);
    int goal;
    int pos;
    goal = n_sent + n_items;
    while (n_sent < goal) begin
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 6)) push_rows(4'($urandom_range(0, 15)));
      end else begin
        if (grp_pos == 0) grp_secret = 1'($urandom_range(0, 1));
        // enrolled code is 1,2,3,A: pad positions 0..3
        if (grp_secret) begin
          pos = grp_pos;
        end else begin
          pos = $urandom_range(0, 15);
          if ((pos == POS_STAR || pos == POS_HASH) && $urandom_range(0, 3) != 0)
            pos = POS_ZERO;
        end
        hit_key(pos);
        grp_pos = (grp_pos + 1) % 4;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = kcl_pkg::CFG_DEBOUNCE;
    cfg_wdata = 8'd0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_idle = 1'b1;
    out_idle = 1'b1;
    deb_now = 8'd20;
    per_now = 4'd2;
    pad_col = 2'd0;
    pad_scan = 0;
    grp_pos = 0;
    n_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no debounce, column steps every tick: every key on the pad in turn,
    // the first four enroll the code
    set_config(8'd0, 4'd1);
    for (int p = 0; p < 16; p++) push_rows(~(4'b0001 << (p / 4)));
    repeat (4) push_rows(4'hF);
    repeat (4) push_rows(4'h0);  // all rows down, row 3 (star, 0, hash, D) wins

    set_config(8'd20, 4'd2);
    run_keypad(180);
    set_config(8'd3, 4'd1);
    run_keypad(180);
    set_config(8'd0, 4'd15);
    run_keypad(1);
    set_config(8'd1, 4'd0);  // zero period scans like one
    run_keypad(90);
    set_config(8'd255, 4'd1);
    repeat (280) push_rows(4'($urandom_range(0, 15)));
    set_config(8'($urandom_range(0, 10)), 4'($urandom_range(1, 3)));
    run_keypad(90);
    set_config(8'd2, 4'd1);
    in_idle = 1'b0;
    out_idle = 1'b0;
    run_keypad(110);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
